>>> rtl/imu_vibration_magnitude_macros.svh
// assertion macros shared by the imu vibration magnitude rtl
`ifndef IMU_VIBRATION_MAGNITUDE_MACROS_SVH
`define IMU_VIBRATION_MAGNITUDE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IVM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ivm_pkg.sv
// types, constants and the square-root step shared by the imu vibration magnitude rtl
`timescale 1ns / 1ps
`default_nettype none

package ivm_pkg;

    // field widths
    localparam int IN_W       = 16;
    localparam int VIB_W      = 16;
    localparam int TEMP_OUT_W = 17;
    localparam int ONE_G_W    = 15;
    localparam int OFF_W      = 16;

    // vector magnitude datapath
    localparam int AXES      = 3;
    localparam int LANES     = 2;
    localparam int LANE_ACC  = 0;
    localparam int LANE_GYR  = 1;
    localparam int SQ_W      = 2 * IN_W - 1;
    localparam int SUM_W     = 2 * IN_W;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
    localparam logic [ROOT_W-1:0] MAX_ROOT = 16'd56755;

    // temperature: floor((10*raw + 17) / 34), biased positive by 34*9638
    localparam int TEMP_X_W      = 21;
    localparam int TEMP_U_W      = 20;
    localparam int TEMP_RECIP_W  = 21;
    localparam int TEMP_SHIFT    = 26;
    localparam int QUOT_W        = 15;
    localparam int TEMP_SUM_W    = 18;
    localparam logic signed [TEMP_X_W-1:0] TEMP_SCALE = 21'sd10;
    localparam logic signed [TEMP_X_W-1:0] TEMP_BIAS  = 21'sd327709;
    localparam logic [TEMP_RECIP_W-1:0]    TEMP_RECIP = 21'd1973791;
    localparam logic signed [TEMP_SUM_W-1:0] TEMP_Q_BIAS = 18'sd9638;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ONE_G_W-1:0]      ONE_G_RESET    = 15'd16384;
    localparam logic signed [OFF_W-1:0] TEMP_OFF_RESET = 16'sd3653;

    typedef enum logic {
        REG_ONE_G    = 1'b0,
        REG_TEMP_OFF = 1'b1
    } t_reg_idx;

    // one lane of the digit-by-digit square root
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  rad;
    } t_sq_state;

    // request into and response out of the square-root pipeline
    typedef struct packed {
        logic [SUM_W-1:0]  sum_a;
        logic [SUM_W-1:0]  sum_g;
        logic [QUOT_W-1:0] quot;
    } t_sq_req;

    typedef struct packed {
        logic [ROOT_W-1:0] root_a;
        logic [ROOT_W-1:0] root_g;
        logic [QUOT_W-1:0] quot;
    } t_sq_rsp;

    // SQ_STEPS result bits of the restoring square root
    function automatic t_sq_state sq_step(t_sq_state s);
        t_sq_state        r;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        r = s;
        for (int i = 0; i < SQ_STEPS; i++) begin
            cur   = {r.rem[REM_W-3:0], r.rad[SUM_W-1:SUM_W-2]};
            trial = {r.root, 2'b01};
            r.rad = {r.rad[SUM_W-3:0], 2'b00};
            if (cur >= trial) begin
                r.rem  = cur - trial;
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end else begin
                r.rem  = cur;
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ivm_sample_if.sv
// request channel carrying one inertial sample set
`timescale 1ns / 1ps
`default_nettype none

interface ivm_sample_if import ivm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] accel_x;
    logic signed [IN_W-1:0] accel_y;
    logic signed [IN_W-1:0] accel_z;
    logic signed [IN_W-1:0] temp_raw;
    logic signed [IN_W-1:0] gyro_x;
    logic signed [IN_W-1:0] gyro_y;
    logic signed [IN_W-1:0] gyro_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, temp_raw, gyro_x, gyro_y, gyro_z,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, temp_raw, gyro_x, gyro_y, gyro_z,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/ivm_result_if.sv
// request channel carrying one vibration, rotation-rate magnitude and temperature result
`timescale 1ns / 1ps
`default_nettype none

interface ivm_result_if import ivm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [VIB_W-1:0]             accel_vibration;
    logic [VIB_W-1:0]             gyro_magnitude;
    logic signed [TEMP_OUT_W-1:0] temperature_centi;

    modport source (
        output valid, accel_vibration, gyro_magnitude, temperature_centi,
        input  ready
    );
    modport sink (
        input  valid, accel_vibration, gyro_magnitude, temperature_centi,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/ivm_isqrt_pipe.sv
// pipelined two-lane integer square root with a temperature sideband
`timescale 1ns / 1ps
`default_nettype none
`include "imu_vibration_magnitude_macros.svh"

module ivm_isqrt_pipe import ivm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_sq_req i_req,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_sq_rsp      o_rsp
);

    localparam int LAST = SQ_STAGES - 1;

    logic [SQ_STAGES-1:0] r_vld;
    logic [SQ_STAGES:0]   w_en;
    logic [SQ_STAGES-1:0] w_vin;
    t_sq_state            r_st  [SQ_STAGES][LANES];
    t_sq_state            n_st  [SQ_STAGES][LANES];
    t_sq_state            w_in  [SQ_STAGES][LANES];
    logic [QUOT_W-1:0]    r_quot[SQ_STAGES];
    logic [QUOT_W-1:0]    w_qin [SQ_STAGES];
    logic [SUM_W-1:0]     w_sum [LANES];

    // lane inputs
    assign w_sum[LANE_ACC] = i_req.sum_a;
    assign w_sum[LANE_GYR] = i_req.sum_g;

    // a stage moves when it is empty or the next one moves
    assign w_en[SQ_STAGES] = i_ready;

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_vin[k] = i_valid;
            assign w_qin[k] = i_req.quot;
        end else begin : g_next
            assign w_vin[k] = r_vld[k-1];
            assign w_qin[k] = r_quot[k-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            if (k == 0) begin : g_seed
                assign w_in[k][l] = '{rem: '0, root: '0, rad: w_sum[l]};
            end else begin : g_chain
                assign w_in[k][l] = r_st[k-1][l];
            end
            assign n_st[k][l] = sq_step(w_in[k][l]);
        end

        assign w_en[k] = !r_vld[k] || w_en[k+1];

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_st[k]   <= n_st[k];
                r_quot[k] <= w_qin[k];
            end
        end
    end

    // outputs
    assign o_ready      = w_en[0];
    assign o_valid      = r_vld[LAST];
    assign o_rsp.root_a = r_st[LAST][LANE_ACC].root;
    assign o_rsp.root_g = r_st[LAST][LANE_GYR].root;
    assign o_rsp.quot   = r_quot[LAST];

    // checks
    `IVM_ASSERT_NOW(a_sq_rad_drained, i_clk, i_rst_n, r_vld[LAST], (r_st[LAST][LANE_ACC].rad == '0) && (r_st[LAST][LANE_GYR].rad == '0), "square root finished with radicand bits left")
    `IVM_ASSERT_NOW(a_sq_root_range, i_clk, i_rst_n, r_vld[LAST], (r_st[LAST][LANE_ACC].root <= MAX_ROOT) && (r_st[LAST][LANE_GYR].root <= MAX_ROOT), "root above largest magnitude")
    `IVM_ASSERT_NEXT(a_sq_hold, i_clk, i_rst_n, r_vld[LAST] && !i_ready, r_vld[LAST] && $stable(r_st[LAST][LANE_ACC].root) && $stable(r_quot[LAST]), "stalled root changed")

endmodule

`default_nettype wire

>>> rtl/imu_vibration_magnitude.sv
// top level: imu vibration, rotation-rate magnitude and temperature pipeline
// usage
//   i_sample is a valid/ready request channel with one sample set of seven
//   signed words; o_result returns one request per sample with the
//   acceleration vibration |isqrt(ax^2+ay^2+az^2) - one_g|, the rotation-rate
//   magnitude isqrt(gx^2+gy^2+gz^2) and the temperature in hundredths.
//   the apb port holds one_g_level (0x0) and temp_offset_centi (0x4); write
//   them only while no sample is in flight. pready is tied high.
//   the accepting edge loads the squares; the result is then registered in
//   turn by the sums, eight square-root stages and output register.
//   throughput: one sample per cycle while the receiver takes results; the
//   square root resolves two root bits per stage in each of its eight stages.
//   reset clears every stage valid and loads the register defaults
//   (one_g 16384, offset 3653).
//   when the receiver stalls, each full stage holds while empty stages ahead
//   of it keep filling; i_sample.ready drops only once all 11 stages hold data.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_vibration_magnitude_macros.svh"

module imu_vibration_magnitude import ivm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    ivm_sample_if.sink             i_sample,
    ivm_result_if.source           o_result
);

    // configuration registers
    logic [ONE_G_W-1:0]      r_one_g;
    logic signed [OFF_W-1:0] r_temp_off;
    logic                    w_cfg_wr;
    t_reg_idx                w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_g    <= ONE_G_RESET;
            r_temp_off <= TEMP_OFF_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_ONE_G:    r_one_g    <= pwdata[ONE_G_W-1:0];
                REG_TEMP_OFF: r_temp_off <= pwdata[OFF_W-1:0];
                default:      r_one_g    <= r_one_g;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_reg_idx)
            REG_ONE_G:    prdata = DATA_W'(r_one_g);
            REG_TEMP_OFF: prdata = DATA_W'(r_temp_off);
            default:      prdata = '0;
        endcase
    end

    // pipeline control
    logic    r_a_vld;
    logic    r_b_vld;
    logic    r_o_vld;
    logic    w_en_a;
    logic    w_en_b;
    logic    w_en_o;
    logic    w_sq_ready;
    logic    w_sq_vld;
    t_sq_req w_sq_req;
    t_sq_rsp w_sq_rsp;

    assign w_en_o         = !r_o_vld || o_result.ready;
    assign w_en_b         = !r_b_vld || w_sq_ready;
    assign w_en_a         = !r_a_vld || w_en_b;
    assign i_sample.ready = w_en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_vld <= i_sample.valid;
            end
            if (w_en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (w_en_o) begin
                r_o_vld <= w_sq_vld;
            end
        end
    end

    // stage a: squares and biased temperature numerator
    logic signed [IN_W-1:0]     w_axis [LANES][AXES];
    logic signed [SUM_W-1:0]    w_prod [LANES][AXES];
    logic [SQ_W-1:0]            n_a_sq [LANES][AXES];
    logic [SQ_W-1:0]            r_a_sq [LANES][AXES];
    logic signed [TEMP_X_W-1:0] w_tr_x;
    logic signed [TEMP_X_W-1:0] w_u_s;
    logic [TEMP_U_W-1:0]        n_a_u;
    logic [TEMP_U_W-1:0]        r_a_u;

    assign w_axis[LANE_ACC][0] = i_sample.accel_x;
    assign w_axis[LANE_ACC][1] = i_sample.accel_y;
    assign w_axis[LANE_ACC][2] = i_sample.accel_z;
    assign w_axis[LANE_GYR][0] = i_sample.gyro_x;
    assign w_axis[LANE_GYR][1] = i_sample.gyro_y;
    assign w_axis[LANE_GYR][2] = i_sample.gyro_z;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            for (int j = 0; j < AXES; j++) begin
                w_prod[l][j] = w_axis[l][j] * w_axis[l][j];
                n_a_sq[l][j] = w_prod[l][j][SQ_W-1:0];
            end
        end
        w_tr_x = TEMP_X_W'(i_sample.temp_raw);
        w_u_s  = w_tr_x * TEMP_SCALE + TEMP_BIAS;
        n_a_u  = w_u_s[TEMP_U_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_sq <= n_a_sq;
            r_a_u  <= n_a_u;
        end
    end

    // stage b: sums of squares and reciprocal multiply for the divide by 34
    logic [SUM_W-1:0]                   n_b_sum [LANES];
    logic [SUM_W-1:0]                   r_b_sum [LANES];
    logic [TEMP_U_W+TEMP_RECIP_W-1:0]   w_t_prod;
    logic [QUOT_W-1:0]                  n_b_quot;
    logic [QUOT_W-1:0]                  r_b_quot;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_b_sum[l] = SUM_W'(r_a_sq[l][0]) + SUM_W'(r_a_sq[l][1]) + SUM_W'(r_a_sq[l][2]);
        end
        w_t_prod = r_a_u * TEMP_RECIP;
        n_b_quot = w_t_prod[TEMP_SHIFT +: QUOT_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_sum  <= n_b_sum;
            r_b_quot <= n_b_quot;
        end
    end

    // square-root pipeline
    assign w_sq_req.sum_a = r_b_sum[LANE_ACC];
    assign w_sq_req.sum_g = r_b_sum[LANE_GYR];
    assign w_sq_req.quot  = r_b_quot;

    ivm_isqrt_pipe u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .o_ready (w_sq_ready),
        .i_req   (w_sq_req),
        .o_valid (w_sq_vld),
        .i_ready (w_en_o),
        .o_rsp   (w_sq_rsp)
    );

    // output stage: vibration, rotation-rate magnitude and offset temperature
    logic [VIB_W-1:0]               w_one_g_x;
    logic [VIB_W-1:0]               n_o_vib;
    logic [VIB_W-1:0]               r_o_vib;
    logic [VIB_W-1:0]               r_o_gyr;
    logic signed [TEMP_SUM_W-1:0]   w_quot_s;
    logic signed [TEMP_SUM_W-1:0]   w_off_s;
    logic signed [TEMP_SUM_W-1:0]   w_temp_sum;
    logic signed [TEMP_OUT_W-1:0]   n_o_temp;
    logic signed [TEMP_OUT_W-1:0]   r_o_temp;

    always_comb begin
        w_one_g_x = VIB_W'(r_one_g);
        if (w_sq_rsp.root_a >= w_one_g_x) begin
            n_o_vib = w_sq_rsp.root_a - w_one_g_x;
        end else begin
            n_o_vib = w_one_g_x - w_sq_rsp.root_a;
        end
        w_quot_s   = signed'(TEMP_SUM_W'(w_sq_rsp.quot));
        w_off_s    = TEMP_SUM_W'(r_temp_off);
        w_temp_sum = w_quot_s - TEMP_Q_BIAS + w_off_s;
        n_o_temp   = w_temp_sum[TEMP_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o) begin
            r_o_vib  <= n_o_vib;
            r_o_gyr  <= w_sq_rsp.root_g;
            r_o_temp <= n_o_temp;
        end
    end

    assign o_result.valid             = r_o_vld;
    assign o_result.accel_vibration   = r_o_vib;
    assign o_result.gyro_magnitude    = r_o_gyr;
    assign o_result.temperature_centi = r_o_temp;

    // checks
    `IVM_ASSERT_NEXT(a_stage_a_hold, i_clk, i_rst_n, r_a_vld && !w_en_b, r_a_vld && $stable(r_a_u), "stalled first stage changed")
    `IVM_ASSERT_NOW(a_out_from_core, i_clk, i_rst_n, $rose(r_o_vld), $past(w_sq_vld), "result raised without a root")
    `IVM_ASSERT_NEXT(a_out_capture, i_clk, i_rst_n, w_en_o && w_sq_vld, r_o_vld, "root dropped at the output stage")

endmodule

`default_nettype wire
